// ===== sv/morton_order_point_sorter_macros.svh =====
// Assertion macros shared by the Morton order point sorter RTL.
`ifndef MORTON_ORDER_POINT_SORTER_MACROS_SVH
`define MORTON_ORDER_POINT_SORTER_MACROS_SVH

// ante implies cons on the same edge
`define MOPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// expr never holds
`define MOPS_ASSERT_NEVER(lbl, expr, msg) \
    `MOPS_ASSERT_IMPL(lbl, 1'b1, !(expr), msg)

`endif

// ===== sv/mops_pkg.sv =====
// Types and bit interleave functions for the Morton order point sorter.
package mops_pkg;

    localparam int COORD_W = 16;
    localparam int CODE_W  = 32;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CODE_W-1:0]  code_t;

    typedef struct packed {
        logic  vld;
        code_t key;
    } link_t;

    function automatic code_t spread16(input coord_t v);
        code_t r;
        r = {16'h0000, v};
        r = (r ^ (r << 8)) & 32'h00ff00ff;
        r = (r ^ (r << 4)) & 32'h0f0f0f0f;
        r = (r ^ (r << 2)) & 32'h33333333;
        r = (r ^ (r << 1)) & 32'h55555555;
        return r;
    endfunction

    function automatic coord_t gather16(input code_t v);
        code_t r;
        r = v & 32'h55555555;
        r = (r ^ (r >> 1)) & 32'h33333333;
        r = (r ^ (r >> 2)) & 32'h0f0f0f0f;
        r = (r ^ (r >> 4)) & 32'h00ff00ff;
        r = (r ^ (r >> 8)) & 32'h0000ffff;
        return r[COORD_W-1:0];
    endfunction

    function automatic code_t interleave(input coord_t xv, input coord_t yv);
        return (spread16(yv) << 1) | spread16(xv);
    endfunction

endpackage

// ===== sv/mops_cell.sv =====
// Insertion sort cell: keeps smaller code, passes larger right, or shifts left.
module mops_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  mops_pkg::link_t link_in,
    output mops_pkg::link_t link_out,
    input  logic           shift,
    input  logic           right_full,
    input  mops_pkg::code_t right_key,
    output logic           full,
    output mops_pkg::code_t key
);
    import mops_pkg::*;

    logic  full_reg;
    logic  full_next;
    code_t key_reg;
    code_t key_next;
    logic  pass_vld_reg;
    logic  pass_vld_next;
    code_t pass_key_reg;
    code_t pass_key_next;

    always_comb
    begin
        full_next     = full_reg;
        key_next      = key_reg;
        pass_vld_next = 1'b0;
        pass_key_next = pass_key_reg;
        if (shift)
        begin
            full_next = right_full;
            key_next  = right_key;
        end
        else if (link_in.vld)
        begin
            if (!full_reg)
            begin
                full_next = 1'b1;
                key_next  = link_in.key;
            end
            else if (link_in.key < key_reg)
            begin
                key_next      = link_in.key;
                pass_vld_next = 1'b1;
                pass_key_next = key_reg;
            end
            else
            begin
                pass_vld_next = 1'b1;
                pass_key_next = link_in.key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg     <= 1'b0;
            pass_vld_reg <= 1'b0;
        end
        else
        begin
            full_reg     <= full_next;
            pass_vld_reg <= pass_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        pass_key_reg <= pass_key_next;
    end

    assign full         = full_reg;
    assign key          = key_reg;
    assign link_out.vld = pass_vld_reg;
    assign link_out.key = pass_key_reg;

endmodule

// ===== sv/morton_order_point_sorter.sv =====
// Morton order point sorter top level: load, settle and drain of a systolic cell row.
//
//  channel | direction | handshake              | fields
//  input   | in        | in_valid / in_stall    | x_coord, y_coord, last_point
//  output  | out       | out_valid / out_stall  | x_sorted, y_sorted, last_sorted, overflow
//
// Load takes one word per cycle; each stored code enters cell 0 and ripples right one cell a cycle.
// After the last point the row settles in ST_SETTLE, then one sorted word leaves
// per cycle from cell 0 while the output is not stalled.
// Input is stalled from the last point until the final sorted word is registered.
// Output stall on a valid word holds the output register and freezes the drain; rst_n clears all control.
module morton_order_point_sorter #(
    parameter int MAX_POINTS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mops_pkg::coord_t     x_coord,
    input  mops_pkg::coord_t     y_coord,
    input  logic                 last_point,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mops_pkg::coord_t     x_sorted,
    output mops_pkg::coord_t     y_sorted,
    output logic                 last_sorted,
    output logic                 overflow
);
    import mops_pkg::*;

    `include "morton_order_point_sorter_macros.svh"

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SET_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [1:0] {ST_LOAD, ST_SETTLE, ST_DRAIN} state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [SET_W-1:0]   settle_reg;
    logic [SET_W-1:0]   settle_next;
    logic               dropped_reg;
    logic               dropped_next;
    logic               out_vld_reg;
    logic               out_vld_next;
    coord_t             x_reg;
    coord_t             x_next;
    coord_t             y_reg;
    coord_t             y_next;
    logic               last_reg;
    logic               last_next;
    logic               ovf_reg;
    logic               ovf_next;

    link_t              link [MAX_POINTS+1];
    logic               cell_full [MAX_POINTS+1];
    code_t              cell_key [MAX_POINTS+1];
    logic               in_acc;
    logic               shift;

    assign in_stall = (state_reg != ST_LOAD);
    assign in_acc   = in_valid && !in_stall;
    assign shift    = (state_reg == ST_DRAIN) && (!out_vld_reg || !out_stall);

    assign link[0].vld = in_acc && (cnt_reg < CNT_W'(MAX_POINTS));
    assign link[0].key = interleave(x_coord, y_coord);

    assign cell_full[MAX_POINTS] = 1'b0;
    assign cell_key[MAX_POINTS]  = '0;

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        mops_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .link_in    (link[i]),
            .link_out   (link[i+1]),
            .shift      (shift),
            .right_full (cell_full[i+1]),
            .right_key  (cell_key[i+1]),
            .full       (cell_full[i]),
            .key        (cell_key[i])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        settle_next  = settle_reg;
        dropped_next = dropped_reg;
        out_vld_next = out_vld_reg && out_stall;
        x_next       = x_reg;
        y_next       = y_reg;
        last_next    = last_reg;
        ovf_next     = ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (link[0].vld)
                        cnt_next = cnt_reg + CNT_W'(1);
                    else
                        dropped_next = 1'b1;
                    if (last_point)
                    begin
                        settle_next = '0;
                        state_next  = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE:
            begin
                settle_next = settle_reg + SET_W'(1);
                if (settle_reg == SET_W'(MAX_POINTS - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (shift)
                begin
                    out_vld_next = 1'b1;
                    x_next       = gather16(cell_key[0]);
                    y_next       = gather16(cell_key[0] >> 1);
                    last_next    = (cnt_reg == CNT_W'(1));
                    ovf_next     = dropped_reg;
                    cnt_next     = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            settle_reg  <= '0;
            dropped_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            settle_reg  <= settle_next;
            dropped_reg <= dropped_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        last_reg <= last_next;
        ovf_reg  <= ovf_next;
    end

    assign out_valid   = out_vld_reg;
    assign x_sorted    = x_reg;
    assign y_sorted    = y_reg;
    assign last_sorted = last_reg;
    assign overflow    = ovf_reg;

    `MOPS_ASSERT_NEVER(a_no_spill, link[MAX_POINTS].vld, "code pushed past the last cell")
    `MOPS_ASSERT_NEVER(a_cnt_range, cnt_reg > CNT_W'(MAX_POINTS), "point count above capacity")
    `MOPS_ASSERT_IMPL(a_drain_full, state_reg == ST_DRAIN && cnt_reg != '0, cell_full[0],
        "draining from an empty head cell")
    `MOPS_ASSERT_IMPL(a_load_empty, state_reg == ST_LOAD && cnt_reg == '0, !cell_full[0],
        "head cell holds a code at the start of a set")

endmodule
